// ===== rtl/olt_pkg.sv =====
// olt_pkg: shared types, sizes and codes for the ordered list table.
// Used by every module of the block and by its checker; no dependencies.
`default_nettype none

package olt_pkg;

    // List capacity and the widths that follow from it
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int DATA_W   = 32;

    // First-match search: groups of eight match bits
    localparam int GRP_SIZE = 8;
    localparam int GRP_W    = 3;
    localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int CAP_PAD  = NGRP * GRP_SIZE;

    // Operation codes
    localparam logic [2:0] KIND_FRONT  = 3'd0;
    localparam logic [2:0] KIND_END    = 3'd1;
    localparam logic [2:0] KIND_AT     = 3'd2;
    localparam logic [2:0] KIND_DELETE = 3'd3;
    localparam logic [2:0] KIND_SEARCH = 3'd4;
    localparam logic [2:0] KIND_CLEAR  = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [7:0] NOT_FOUND = -8'sd1;

    // Request and response words
    typedef struct packed {
        logic [2:0]              kind;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } olt_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic signed [7:0] found_position;
        logic [6:0]        count;
    } olt_rsp_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic              ins;
        logic              del;
        logic              srch;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  count;
    } olt_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/olt_cell.sv =====
// olt_cell: one slot of the list; shifts with its neighbors on insert/delete
// and compares its entry on search. Depends on olt_pkg.
`default_nettype none

module olt_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [olt_pkg::IDX_W-1:0]     slot,
    input  olt_pkg::olt_ctrl_t            ctrl,
    input  logic [olt_pkg::DATA_W-1:0]    left_data,
    input  logic [olt_pkg::DATA_W-1:0]    right_data,
    output logic [olt_pkg::DATA_W-1:0]    data,
    output logic                          match
);

    logic [olt_pkg::DATA_W-1:0] data_reg;
    logic [olt_pkg::DATA_W-1:0] data_next;
    logic                       match_reg;
    logic                       match_next;

    // Entry update: take the new value at an insert point, the left word above
    // it, the right word at or above a delete point
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (slot == ctrl.idx)
                data_next = ctrl.value;
            else if (slot > ctrl.idx)
                data_next = left_data;
        end
        else if (ctrl.del)
        begin
            if (slot >= ctrl.idx)
                data_next = right_data;
        end
    end

    // Search compare, only for slots holding a live entry
    assign match_next = ctrl.srch && (olt_pkg::CNT_W'(slot) < ctrl.count)
                        && (data_reg == ctrl.value);

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else
            match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ===== rtl/ordered_list_table.sv =====
// ordered_list_table: top level; controller, the row of list cells and the
// first-match encoder. Depends on olt_pkg and olt_cell.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one operation word: kind,
//   1-based position and a signed 32-bit value. rsp channel (rsp_valid/
//   rsp_ready/rsp) returns one word per request: status, found position
//   (-1 when none) and the entry count after the operation.
//   One request is in flight at a time. An accepted request has its
//   response registered at the end of its last step, and the next request is
//   taken only when the block is back in its first step, so the block never
//   takes a new operation before the last one is through. The four steps are:
//   capture, cell update and compare, per-group match encode, group select into the output register.
//   Entries live in a row of cells that shift one place toward their
//   neighbor on insert or delete, so all moves happen in the update step.
//   Reset clears the count and all control state; the entries are not
//   cleared and are only read below the count.
//   The response sits in its own register: while the receiver stalls the
//   block still takes and processes the next request, then waits in its
//   last step until the output register frees up.
`default_nettype none

module ordered_list_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  olt_pkg::olt_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output olt_pkg::olt_rsp_t rsp
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_GRP  = 4'b0100,
        S_FIND = 4'b1000
    } olt_state_t;

    olt_state_t state_reg, state_next;

    olt_pkg::olt_req_t          cmd_reg;
    logic [olt_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [1:0]                 status_reg, status_next;
    olt_pkg::olt_rsp_t          rsp_reg, rsp_next;
    logic                       rsp_valid_reg, rsp_valid_next;

    logic [olt_pkg::NGRP-1:0]   grp_hit_reg;
    logic [olt_pkg::NGRP-1:0]   grp_hit_next;
    logic [olt_pkg::GRP_W-1:0]  grp_low_reg  [olt_pkg::NGRP];
    logic [olt_pkg::GRP_W-1:0]  grp_low_next [olt_pkg::NGRP];

    olt_pkg::olt_ctrl_t         ctrl;
    logic [olt_pkg::DATA_W-1:0] cell_data [olt_pkg::CAPACITY];
    logic [olt_pkg::CAPACITY-1:0] match_vec;
    logic [olt_pkg::CAP_PAD-1:0]  match_pad;

    logic [olt_pkg::CMP_W-1:0]  cnt_ext;
    logic [olt_pkg::CMP_W-1:0]  pos_ext;
    logic [olt_pkg::CMP_W-1:0]  op_pos;
    logic                       full;
    logic                       ins_ok;
    logic                       del_ok;
    logic                       srch;
    logic                       exec;
    logic                       out_free;
    logic signed [7:0]          found_pos;

    assign req_ready = (state_reg == S_IDLE);
    assign exec      = (state_reg == S_EXEC);
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // Operation decode and range/full checks for the word in cmd_reg
    assign cnt_ext = olt_pkg::CMP_W'(count_reg);
    assign pos_ext = olt_pkg::CMP_W'(cmd_reg.position);
    assign full    = (count_reg >= olt_pkg::CNT_W'(olt_pkg::CAPACITY));

    always_comb
    begin
        ins_ok      = 1'b0;
        del_ok      = 1'b0;
        srch        = 1'b0;
        op_pos      = olt_pkg::CMP_W'(1);
        status_next = olt_pkg::ST_OK;
        count_next  = count_reg;
        case (cmd_reg.kind)
            olt_pkg::KIND_FRONT:
            begin
                status_next = full ? olt_pkg::ST_FULL : olt_pkg::ST_OK;
                ins_ok      = !full;
            end
            olt_pkg::KIND_END:
            begin
                op_pos      = cnt_ext + olt_pkg::CMP_W'(1);
                status_next = full ? olt_pkg::ST_FULL : olt_pkg::ST_OK;
                ins_ok      = !full;
            end
            olt_pkg::KIND_AT:
            begin
                op_pos = pos_ext;
                if (pos_ext == '0 || pos_ext > cnt_ext + olt_pkg::CMP_W'(1))
                    status_next = olt_pkg::ST_RANGE;
                else if (full)
                    status_next = olt_pkg::ST_FULL;
                else
                    ins_ok = 1'b1;
            end
            olt_pkg::KIND_DELETE:
            begin
                op_pos = pos_ext;
                if (pos_ext == '0 || pos_ext > cnt_ext)
                    status_next = olt_pkg::ST_RANGE;
                else
                    del_ok = 1'b1;
            end
            olt_pkg::KIND_SEARCH:
            begin
                srch = 1'b1;
            end
            olt_pkg::KIND_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status_next = olt_pkg::ST_OK;
            end
        endcase
        if (ins_ok)
            count_next = count_reg + olt_pkg::CNT_W'(1);
        else if (del_ok)
            count_next = count_reg - olt_pkg::CNT_W'(1);
    end

    // Broadcast to the cells, active in the update step only
    always_comb
    begin
        ctrl.ins   = exec && ins_ok;
        ctrl.del   = exec && del_ok;
        ctrl.srch  = exec && srch;
        ctrl.idx   = olt_pkg::IDX_W'(op_pos - olt_pkg::CMP_W'(1));
        ctrl.value = cmd_reg.value;
        ctrl.count = count_reg;
    end

    // Row of cells, each wired to its two neighbors
    for (genvar i = 0; i < olt_pkg::CAPACITY; i++)
    begin : g_cell
        logic [olt_pkg::DATA_W-1:0] left_w;
        logic [olt_pkg::DATA_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == olt_pkg::CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        olt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .slot       (olt_pkg::IDX_W'(i)),
            .ctrl       (ctrl),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .match      (match_vec[i])
        );
    end

    // First match within each group of eight
    assign match_pad = olt_pkg::CAP_PAD'(match_vec);

    always_comb
    begin
        for (int g = 0; g < olt_pkg::NGRP; g++)
        begin
            grp_hit_next[g] = |match_pad[g*olt_pkg::GRP_SIZE +: olt_pkg::GRP_SIZE];
            grp_low_next[g] = '0;
            for (int k = olt_pkg::GRP_SIZE - 1; k >= 0; k--)
            begin
                if (match_pad[g*olt_pkg::GRP_SIZE + k])
                    grp_low_next[g] = olt_pkg::GRP_W'(k);
            end
        end
    end

    // First hitting group gives the 1-based position
    always_comb
    begin
        found_pos = olt_pkg::NOT_FOUND;
        for (int g = olt_pkg::NGRP - 1; g >= 0; g--)
        begin
            if (grp_hit_reg[g])
                found_pos = 8'(g * olt_pkg::GRP_SIZE) + 8'(grp_low_reg[g]) + 8'sd1;
        end
    end

    // Sequencer and output register
    always_comb
    begin
        state_next     = state_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_GRP;
            end
            S_GRP:
            begin
                state_next = S_FIND;
            end
            S_FIND:
            begin
                if (out_free)
                begin
                    rsp_next.status         = status_reg;
                    rsp_next.found_position = found_pos;
                    rsp_next.count          = 7'(count_reg);
                    rsp_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            status_reg    <= olt_pkg::ST_OK;
            rsp_valid_reg <= 1'b0;
            grp_hit_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec)
            begin
                count_reg  <= count_next;
                status_reg <= status_next;
            end
            if (state_reg == S_GRP)
                grp_hit_reg <= grp_hit_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            cmd_reg <= req;
        if (state_reg == S_GRP)
            grp_low_reg <= grp_low_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/olt_checker.sv =====
// olt_checker: port-level assertions for ordered_list_table, bound to it.
// Depends on olt_pkg and the top level's ports.
`default_nettype none

module olt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input olt_pkg::olt_req_t req,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input olt_pkg::olt_rsp_t rsp
);

    // Reported count never exceeds the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp.count) <= olt_pkg::CAPACITY))
        else $error("count above capacity");

    // A found position comes with ok status and lies within the list
    a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.found_position != olt_pkg::NOT_FOUND) |->
        (rsp.status == olt_pkg::ST_OK && rsp.found_position > 8'sd0
         && 32'(rsp.found_position) <= 32'(rsp.count)))
        else $error("found position out of list");

    // One word in flight: no request is taken right after one was accepted
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted back to back");

    // A waiting request word holds until it is taken
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_ready) |=> (req_valid && $stable(req)))
        else $error("request dropped or changed while waiting");

    // A stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("response dropped or changed under stall");

endmodule

bind ordered_list_table olt_checker u_olt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

// ===== dv/olt_tb_pkg.sv =====
`timescale 1ns / 100ps
// olt_tb_pkg: list scoreboard for the ordered list table bench. It predicts
// the response word for every accepted request and checks the block output.
// Depends on olt_pkg.
package olt_tb_pkg;
    import olt_pkg::*;

    // Kinds the block treats as no-ops
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    class list_scoreboard;
        logic signed [DATA_W-1:0] cells [CAPACITY];
        int                       fill;
        olt_rsp_t                 pending_rsp [$];
        int                       error_count;

        function new();
            fill        = 0;
            error_count = 0;
        endfunction

        // Open a hole at 1-based pos, drop v into it
        function void shift_in(int pos, logic signed [DATA_W-1:0] v);
            for (int i = fill; i >= pos; i--)
            begin
                cells[i] = cells[i-1];
            end
            cells[pos-1] = v;
            fill++;
        endfunction

        // Apply one accepted request to the list and queue its response word
        function void note_request(olt_req_t r);
            olt_rsp_t e;
            e.status         = ST_OK;
            e.found_position = NOT_FOUND;
            case (r.kind)
                KIND_FRONT:
                begin
                    if (fill >= CAPACITY)
                        e.status = ST_FULL;
                    else
                        shift_in(1, r.value);
                end
                KIND_END:
                begin
                    if (fill >= CAPACITY)
                        e.status = ST_FULL;
                    else
                        shift_in(fill + 1, r.value);
                end
                KIND_AT:
                begin
                    // range check wins over the full check
                    if (r.position == 0 || int'(r.position) > fill + 1)
                        e.status = ST_RANGE;
                    else if (fill >= CAPACITY)
                        e.status = ST_FULL;
                    else
                        shift_in(int'(r.position), r.value);
                end
                KIND_DELETE:
                begin
                    if (r.position == 0 || int'(r.position) > fill)
                        e.status = ST_RANGE;
                    else
                    begin
                        for (int i = int'(r.position); i < fill; i++)
                        begin
                            cells[i-1] = cells[i];
                        end
                        fill--;
                    end
                end
                KIND_SEARCH:
                begin
                    // first match only
                    for (int i = 0; i < fill; i++)
                    begin
                        if (cells[i] == r.value && e.found_position == NOT_FOUND)
                            e.found_position = 8'(i + 1);
                    end
                end
                KIND_CLEAR:
                begin
                    fill = 0;
                end
                default:
                begin
                end
            endcase
            e.count = 7'(fill);
            pending_rsp.push_back(e);
        endfunction

        // Compare one response word with the oldest prediction
        function void check_response(olt_rsp_t got);
            olt_rsp_t exp_rsp;
            if (pending_rsp.size() == 0)
            begin
                $error("response word with nothing outstanding: %p", got);
                error_count++;
                return;
            end
            exp_rsp = pending_rsp.pop_front();
            if (got.status !== exp_rsp.status)
            begin
                $error("status: expected %0d, got %0d", exp_rsp.status, got.status);
                error_count++;
            end
            if (got.found_position !== exp_rsp.found_position)
            begin
                $error("found_position: expected %0d, got %0d",
                       exp_rsp.found_position, got.found_position);
                error_count++;
            end
            if (got.count !== exp_rsp.count)
            begin
                $error("count: expected %0d, got %0d", exp_rsp.count, got.count);
                error_count++;
            end
        endfunction

        // Anything still queued at the end never came back
        function void flag_leftovers();
            if (pending_rsp.size() != 0)
            begin
                $error("%0d response words never arrived", pending_rsp.size());
                error_count++;
            end
        endfunction
    endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: bench for ordered_list_table; drives request words with bursty
// pacing, stalls the response side and checks every word against the scoreboard.
// Depends on olt_pkg, olt_tb_pkg and the block RTL.
module tb_top;
    import olt_pkg::*;
    import olt_tb_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_HOLD    = 200;
    localparam int CYCLE_LIMIT  = 100000;

    typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED, PH_NOISE} phase_e;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    olt_req_t req_word  = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    olt_rsp_t rsp_word;

    list_scoreboard sb = new();
    int             items_sent  = 0;
    int             cycle_count = 0;

    ordered_list_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_word)
    );

    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Response checking
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp_word);
    end

    // Offer one word and hold it until accepted; valid stays up afterwards
    task automatic send_item(input olt_req_t item);
        req_word  <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(item);
        items_sent++;
    endtask

    task automatic send_op(input logic [2:0] kind, input int pos,
                           input logic signed [31:0] value);
        olt_req_t item;
        item.kind     = kind;
        item.position = 7'(pos);
        item.value    = value;
        send_item(item);
    endtask

    // Stop offering until every predicted word has come back
    task automatic wait_for_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Corner-heavy value mix; the small set makes duplicates likely
    function automatic logic signed [31:0] draw_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    // Mostly a value that is in the list, so searches hit
    function automatic logic signed [31:0] pick_search_value();
        if (sb.fill > 0 && $urandom_range(0, 2) != 0)
            return sb.cells[$urandom_range(0, sb.fill - 1)];
        return draw_value();
    endfunction

    // Position in 1..top, with the top edge and out-of-range values mixed in
    function automatic logic [6:0] pick_position(input int top);
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return 7'(top);
        if (roll == 1)
            return ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(top + 1, 127));
        return 7'($urandom_range(1, (top < 1) ? 1 : top));
    endfunction

    // Response side: random stall segments, one long hold-off
    initial
    begin
        int  seg_len;
        int  stall_pct;
        bit  long_hold_done;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && items_sent >= 120)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            seg_len = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                2:       stall_pct = 50;
                default: stall_pct = 90;
            endcase
            repeat (seg_len)
            begin
                rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
                @(posedge clk);
            end
        end
    end

    // Stimulus
    initial
    begin
        olt_req_t item;
        phase_e   phase;
        int       len;
        int       roll;
        int       gap;
        int       burst_left;
        int       issued;
        bit       paused;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, range edges, duplicates, spare kinds, clear
        send_op(KIND_DELETE, 1, 0);
        send_op(KIND_DELETE, 0, 0);
        send_op(KIND_SEARCH, 0, 0);
        send_op(KIND_AT, 0, 1);
        send_op(KIND_AT, 2, 1);
        send_op(KIND_FRONT, 0, 32'sh7FFF_FFFF);
        send_op(KIND_END, 127, 32'sh8000_0000);
        send_op(KIND_AT, 2, -32'sd1);
        send_op(KIND_AT, 4, 0);
        send_op(KIND_AT, 6, 7);
        send_op(KIND_AT, 127, 7);
        send_op(KIND_SEARCH, 0, -32'sd1);
        send_op(KIND_SEARCH, 0, 12345);
        send_op(KIND_FRONT, 0, 0);
        send_op(KIND_SEARCH, 0, 0);
        send_op(KIND_DELETE, 1, 0);
        send_op(KIND_DELETE, 4, 0);
        send_op(KIND_DELETE, 4, 0);
        send_op(KIND_DELETE, 127, 0);
        send_op(KIND_SPARE_6, 1, 32'sh5A5A_5A5A);
        send_op(KIND_SPARE_7, 127, -32'sd1);
        send_op(KIND_CLEAR, 0, 0);
        send_op(KIND_SEARCH, 0, 32'sh8000_0000);
        send_op(KIND_END, 0, 5);
        send_op(KIND_CLEAR, 0, 0);
        wait_for_responses();

        // Random phases; the first one is mostly inserts and grows the list toward full
        issued     = 0;
        burst_left = 0;
        paused     = 1'b0;
        phase      = PH_GROW;
        len        = 90;
        while (issued < RANDOM_ITEMS)
        begin
            repeat (len)
            begin
                roll       = $urandom_range(0, 99);
                item.kind  = KIND_SEARCH;
                item.position = 7'($urandom);
                item.value = draw_value();
                case (phase)
                    PH_GROW:
                    begin
                        if (roll < 85)
                        begin
                            case ($urandom_range(0, 2))
                                0:       item.kind = KIND_FRONT;
                                1:       item.kind = KIND_END;
                                default:
                                begin
                                    item.kind     = KIND_AT;
                                    item.position = pick_position(sb.fill + 1);
                                end
                            endcase
                        end
                        else if (roll < 95)
                            item.value = pick_search_value();
                        else
                        begin
                            item.kind     = KIND_DELETE;
                            item.position = pick_position(sb.fill);
                        end
                    end
                    PH_SHRINK:
                    begin
                        if (roll < 70)
                        begin
                            item.kind     = KIND_DELETE;
                            item.position = pick_position(sb.fill);
                        end
                        else if (roll < 85)
                            item.value = pick_search_value();
                        else if (roll < 97)
                            item.kind = KIND_END;
                        else
                            item.kind = KIND_CLEAR;
                    end
                    PH_MIXED:
                    begin
                        item.kind     = 3'($urandom_range(0, 7));
                        item.position = pick_position(sb.fill + 1);
                        if (item.kind == KIND_SEARCH)
                            item.value = pick_search_value();
                    end
                    default:
                    begin
                        item.kind     = 3'($urandom);
                        item.position = 7'($urandom);
                        item.value    = $urandom;
                    end
                endcase

                // Bursty pacing; some gaps are zero
                if (burst_left == 0)
                begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap != 0)
                    begin
                        req_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 30);
                end
                burst_left--;
                send_item(item);
                issued++;
            end

            // One full drain partway through
            if (!paused && issued >= 200)
            begin
                wait_for_responses();
                paused = 1'b1;
            end

            case ($urandom_range(0, 3))
                0:
                begin
                    phase = PH_GROW;
                    len   = $urandom_range(30, 80);
                end
                1:
                begin
                    phase = PH_SHRINK;
                    len   = $urandom_range(20, 60);
                end
                2:
                begin
                    phase = PH_MIXED;
                    len   = $urandom_range(10, 50);
                end
                default:
                begin
                    phase = PH_NOISE;
                    len   = $urandom_range(5, 20);
                end
            endcase
        end

        wait_for_responses();
        repeat (8) @(posedge clk);
        sb.flag_leftovers();
        if (sb.error_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
